FILE: hw/rtl/tks_pkg.sv
// ----------------------------------------------------------------------------
// tks_pkg: shared types and constants of the top-k score table
// Field widths, command codes, the entry record and the cell link flags.
// ----------------------------------------------------------------------------
`default_nettype none

package tks_pkg;

   localparam int CMD_W        = 2;
   localparam int SCORE_W      = 32;
   localparam int STAGE_W      = 8;
   localparam int TAG_W        = 32;
   localparam int INDEX_W      = 4;
   localparam int RANK_W       = 5;
   localparam int OCC_W        = 5;
   localparam int DEF_CAPACITY = 16;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 2'd0,
      CMD_READ   = 2'd1,
      CMD_RANK   = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef struct packed {
      logic signed [SCORE_W-1:0] score;
      logic [STAGE_W-1:0]        stage;
      logic [TAG_W-1:0]          tag;
   } entry_type;

   // flags a cell hands to its right-hand neighbor
   typedef struct packed {
      logic valid;   // slot holds an entry
      logic ge;      // stored score >= incoming score
      logic eqlow;   // stored score equals the lowest score
      logic lt;      // incoming score < stored score
   } link_type;

   // transaction data broadcast to every cell
   typedef struct packed {
      entry_type                 new_entry;
      logic [INDEX_W-1:0]        index;
      logic signed [SCORE_W-1:0] low;
      logic                      full;
      logic                      commit;
   } bcast_type;

   typedef struct packed {
      entry_type          entry;
      logic               entry_valid;
      logic [RANK_W-1:0]  rank;
      logic               qualifies;
      logic               inserted;
      logic [OCC_W-1:0]   occupancy;
   } rsp_type;

endpackage

`default_nettype wire

FILE: hw/rtl/tks_if.sv
// ----------------------------------------------------------------------------
// tks_if: request and response channels of the top-k score table
// Valid/ready channels; a transaction moves when valid and ready are high.
// ----------------------------------------------------------------------------
`default_nettype none

interface tks_req_if;
   logic                     valid;
   logic                     ready;
   logic [1:0]               command;
   logic signed [31:0]       score;
   logic [7:0]               stage;
   logic [31:0]              tag;
   logic [3:0]               index;

   modport source (output valid, command, score, stage, tag, index, input ready);
   modport sink   (input valid, command, score, stage, tag, index, output ready);
endinterface

interface tks_rsp_if;
   logic                     valid;
   logic                     ready;
   logic signed [31:0]       entry_score;
   logic [7:0]               entry_stage;
   logic [31:0]              entry_tag;
   logic                     entry_valid;
   logic [4:0]               rank;
   logic                     qualifies;
   logic                     inserted;
   logic [4:0]               occupancy;

   modport source (output valid, entry_score, entry_stage, entry_tag, entry_valid,
                   rank, qualifies, inserted, occupancy, input ready);
   modport sink   (input valid, entry_score, entry_stage, entry_tag, entry_valid,
                   rank, qualifies, inserted, occupancy, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/tks_cell.sv
// ----------------------------------------------------------------------------
// tks_cell: one slot of the sorted score table
// Holds one entry, compares it with the broadcast score and on a committed
// insert either keeps it, loads the new entry or takes its left neighbor's.
// ----------------------------------------------------------------------------
`default_nettype none

module tks_cell
   import tks_pkg::*;
#(
   parameter int CAPACITY = DEF_CAPACITY,
   parameter int POSITION = 0
) (
   input  wire logic                                clock,
   input  wire bcast_type                           bcast,
   input  wire logic [$clog2(CAPACITY+1)-1:0]       filled,
   input  wire entry_type                           left_entry,
   input  wire link_type                            left_link,
   output entry_type                                entry_out,
   output link_type                                 link_out,
   output entry_type                                read_out,
   output logic                                     read_hit,
   output logic                                     boundary
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (INDEX_W > CNT_W) ? INDEX_W : CNT_W;

   entry_type entry_ff;
   entry_type entry_in;
   logic      slot_valid;
   logic      take_new;
   logic      take_left;

   assign slot_valid = CNT_W'(POSITION) < filled;

   assign link_out.valid = slot_valid;
   assign link_out.ge    = slot_valid && (entry_ff.score >= bcast.new_entry.score);
   assign link_out.eqlow = slot_valid && (entry_ff.score == bcast.low);
   assign link_out.lt    = slot_valid && (bcast.new_entry.score < entry_ff.score);

   // new entry lands at the first slot that is empty or whose score is below it
   assign take_new  = bcast.commit && !link_out.ge && left_link.ge;
   // shift right up to the end of the list, or up to the dropped lowest entry
   assign take_left = bcast.commit && !left_link.ge &&
                      (bcast.full ? !left_link.eqlow : left_link.valid);

   always_comb begin
      entry_in = entry_ff;
      if (take_new) begin
         entry_in = bcast.new_entry;
      end else if (take_left) begin
         entry_in = left_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_out = entry_ff;
   assign read_hit  = slot_valid && (CMP_W'(bcast.index) == CMP_W'(POSITION));
   assign read_out  = read_hit ? entry_ff : '0;
   assign boundary  = !link_out.lt && left_link.lt;

endmodule

`default_nettype wire

FILE: hw/rtl/top_k_score_table.sv
// ----------------------------------------------------------------------------
// top_k_score_table: sorted table of the highest scored entries
// A row of CAPACITY cells kept in descending score order, with one response
// register toward the sink.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one command per transaction: insert (score, stage, tag), read
//   the entry at index, or rank query for score. rsp returns exactly one
//   response per request, in order.
//   The response is registered at the edge that takes the request. Every
//   cell compares its slot with the broadcast score in the same cycle, so
//   the block takes one request per cycle; the response register limits it,
//   and req.ready is high whenever that register is empty or being drained.
//   While rsp is stalled the response holds and req.ready stays low.
//   Reset empties the table (occupancy zero) and drops any pending response;
//   slot contents are not cleared and are never read before written.
//   An insert into a full table replaces the earliest lowest entry only when
//   the new score is strictly higher; otherwise it is refused.
// ----------------------------------------------------------------------------
`default_nettype none

module top_k_score_table
   import tks_pkg::*;
#(
   parameter int CAPACITY = DEF_CAPACITY
) (
   input  wire logic  clock,
   input  wire logic  reset,
   tks_req_if.sink    req,
   tks_rsp_if.source  rsp
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic [CNT_W-1:0] filled_ff;
   logic [CNT_W-1:0] filled_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   rsp_type          rsp_ff;
   rsp_type          rsp_in;

   entry_type        stored   [CAPACITY];
   entry_type        left_ent [CAPACITY];
   link_type         links    [CAPACITY];
   link_type         left_lnk [CAPACITY];
   entry_type        reads    [CAPACITY];
   logic [CAPACITY-1:0] hits;
   logic [CAPACITY-1:0] bounds;

   bcast_type        bcast;
   cmd_type          cmd;
   logic             accept;
   logic             full;
   logic             qualifies;
   entry_type        read_data;
   logic [CNT_W-1:0] rank_pos;
   logic [CNT_W:0]   rank_sum;

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;
   assign cmd       = cmd_type'(req.command);
   assign full      = filled_ff == CNT_W'(CAPACITY);
   assign qualifies = !full || (req.score > stored[CAPACITY-1].score);

   assign bcast.new_entry.score = req.score;
   assign bcast.new_entry.stage = req.stage;
   assign bcast.new_entry.tag   = req.tag;
   assign bcast.index           = req.index;
   assign bcast.low             = stored[CAPACITY-1].score;
   assign bcast.full            = full;
   assign bcast.commit          = accept && (cmd == CMD_INSERT) && qualifies;

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      if (g == 0) begin : g_head
         assign left_ent[g] = '0;
         assign left_lnk[g] = '{valid: 1'b1, ge: 1'b1, eqlow: 1'b0, lt: 1'b1};
      end else begin : g_link
         assign left_ent[g] = stored[g-1];
         assign left_lnk[g] = links[g-1];
      end

      tks_cell #(
         .CAPACITY (CAPACITY),
         .POSITION (g)
      ) u_cell (
         .clock      (clock),
         .bcast      (bcast),
         .filled     (filled_ff),
         .left_entry (left_ent[g]),
         .left_link  (left_lnk[g]),
         .entry_out  (stored[g]),
         .link_out   (links[g]),
         .read_out   (reads[g]),
         .read_hit   (hits[g]),
         .boundary   (bounds[g])
      );
   end

   // collect the one-hot read and rank answers
   always_comb begin
      read_data = '0;
      rank_pos  = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         read_data = read_data | reads[i];
         if (bounds[i]) begin
            rank_pos = rank_pos | CNT_W'(i);
         end
      end
      if (full && links[CAPACITY-1].lt) begin
         rank_pos = CNT_W'(CAPACITY);
      end
   end

   assign rank_sum = {1'b0, rank_pos} + (CNT_W + 1)'(1);

   always_comb begin
      filled_in = filled_ff;
      if (bcast.commit && !full) begin
         filled_in = filled_ff + CNT_W'(1);
      end
   end

   always_comb begin
      rsp_in           = '0;
      rsp_in.occupancy = OCC_W'(filled_in);
      case (cmd)
         CMD_INSERT: begin
            rsp_in.inserted = qualifies;
         end
         CMD_READ: begin
            rsp_in.entry       = read_data;
            rsp_in.entry_valid = |hits;
         end
         CMD_RANK: begin
            rsp_in.rank      = RANK_W'(rank_sum);
            rsp_in.qualifies = qualifies;
         end
         default: begin
            rsp_in.inserted = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filled_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         filled_ff    <= filled_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the response until the sink takes it
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.entry_score = rsp_ff.entry.score;
   assign rsp.entry_stage = rsp_ff.entry.stage;
   assign rsp.entry_tag   = rsp_ff.entry.tag;
   assign rsp.entry_valid = rsp_ff.entry_valid;
   assign rsp.rank        = rsp_ff.rank;
   assign rsp.qualifies   = rsp_ff.qualifies;
   assign rsp.inserted    = rsp_ff.inserted;
   assign rsp.occupancy   = rsp_ff.occupancy;

endmodule

`default_nettype wire

FILE: hw/rtl/tks_checker.sv
// ----------------------------------------------------------------------------
// tks_checker: port-level checks of the top-k score table
// Latency, response hold, field exclusivity and range of rank and occupancy.
// ----------------------------------------------------------------------------
`default_nettype none

module tks_checker
   import tks_pkg::*;
#(
   parameter int CAPACITY = DEF_CAPACITY
) (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_ready,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic               rsp_entry_valid,
   input wire logic [RANK_W-1:0]  rsp_rank,
   input wire logic               rsp_inserted,
   input wire logic [OCC_W-1:0]   rsp_occupancy
);

   // every accepted request shows a response in the next cycle
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("tks: no response one cycle after request");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_occupancy) && $stable(rsp_rank))
      else $error("tks: stalled response changed");

   // a response carries the results of at most one kind of command
   a_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $countones({rsp_entry_valid, rsp_inserted, rsp_rank != '0}) <= 1)
      else $error("tks: response mixes command results");

   a_occupancy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (CAPACITY > 16) || (rsp_occupancy <= OCC_W'(CAPACITY)))
      else $error("tks: occupancy above capacity");

   a_rank: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (CAPACITY > 16) ||
                    ({1'b0, rsp_rank} <= {1'b0, rsp_occupancy} + (OCC_W + 1)'(1)))
      else $error("tks: rank beyond occupancy plus one");

endmodule

bind top_k_score_table tks_checker #(
   .CAPACITY (CAPACITY)
) u_tks_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req.valid),
   .req_ready       (req.ready),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_entry_valid (rsp.entry_valid),
   .rsp_rank        (rsp.rank),
   .rsp_inserted    (rsp.inserted),
   .rsp_occupancy   (rsp.occupancy)
);

`default_nettype wire

FILE: tb/top_k_score_table_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// top_k_score_table_tb: self-checking bench for the top-k score table
// Drives insert, read, rank and CMD_NONE transactions over the request channel. A
// behavioral copy of the sorted table predicts every response, and each
// response is checked field by field in arrival order. Both channel sides
// idle at random, and one phase holds off the response side long enough to
// stall the request side.
// ----------------------------------------------------------------------------

module top_k_score_table_tb;
   import tks_pkg::*;

   localparam int CAP      = DEF_CAPACITY;
   localparam int HOLD_LEN = 80;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tks_req_if req_ch ();
   tks_rsp_if rsp_ch ();

   top_k_score_table i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // behavioral copy of the table
   logic signed [31:0] tbl_score [CAP];
   logic [7:0]         tbl_stage [CAP];
   logic [31:0]        tbl_tag   [CAP];
   int                 held = 0;

   rsp_type expected_rsp [$];
   int      errors = 0;

   bit src_idle_on  = 1'b1;
   bit sink_idle_on = 1'b1;
   int hold_requests = 0;
   int hold_served   = 0;
   int stall_left    = 0;

   function automatic rsp_type table_response(input cmd_type c, input logic signed [31:0] s,
                                              input logic [7:0] st, input logic [31:0] tg,
                                              input logic [3:0] idx);
      rsp_type r;
      int      pos;
      int      i;
      r = '0;
      case (c)
         CMD_INSERT: begin
            // full table: drop the earliest of the lowest entries if the new one beats it
            if (held == CAP && s > tbl_score[CAP-1]) begin
               pos = 0;
               while (tbl_score[pos] != tbl_score[CAP-1]) pos++;
               for (i = pos; i < CAP - 1; i++) begin
                  tbl_score[i] = tbl_score[i+1];
                  tbl_stage[i] = tbl_stage[i+1];
                  tbl_tag[i]   = tbl_tag[i+1];
               end
               held--;
            end
            if (held < CAP) begin
               pos = 0;
               while (pos < held && tbl_score[pos] >= s) pos++;
               for (i = held; i > pos; i--) begin
                  tbl_score[i] = tbl_score[i-1];
                  tbl_stage[i] = tbl_stage[i-1];
                  tbl_tag[i]   = tbl_tag[i-1];
               end
               tbl_score[pos] = s;
               tbl_stage[pos] = st;
               tbl_tag[pos]   = tg;
               held++;
               r.inserted = 1'b1;
            end
         end
         CMD_READ: begin
            if (int'(idx) < held) begin
               r.entry.score = tbl_score[idx];
               r.entry.stage = tbl_stage[idx];
               r.entry.tag   = tbl_tag[idx];
               r.entry_valid = 1'b1;
            end
         end
         CMD_RANK: begin
            pos = 0;
            while (pos < held && s < tbl_score[pos]) pos++;
            r.rank      = RANK_W'(pos + 1);
            r.qualifies = (held < CAP) || (s > tbl_score[held-1]);
         end
         default: ;
      endcase
      r.occupancy = OCC_W'(held);
      return r;
   endfunction

   // Bias scores toward ties and toward the current lowest entry.
   function automatic logic signed [31:0] pick_score();
      case ($urandom_range(5))
         0: return $urandom;
         1: return int'($urandom_range(16)) - 8;
         2: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         3, 4: begin
            if (held == 0) return $urandom;
            return tbl_score[$urandom_range(held - 1)] + (int'($urandom_range(2)) - 1);
         end
         default: begin
            if (held == 0) return $urandom;
            return tbl_score[held-1] + (int'($urandom_range(2)) - 1);
         end
      endcase
   endfunction

   // Called at a rising edge; returns at the edge that moves the transaction.
   task automatic send_item(input cmd_type c, input logic signed [31:0] s,
                            input logic [7:0] st, input logic [31:0] tg, input logic [3:0] idx);
      int gaps;
      gaps = 0;
      if (src_idle_on)
         while ($urandom_range(99) < 11) gaps++;
      if (gaps > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gaps) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.command <= c;
      req_ch.score   <= s;
      req_ch.stage   <= st;
      req_ch.tag     <= tg;
      req_ch.index   <= idx;
      do @(negedge clock); while (!req_ch.ready);
      expected_rsp.push_back(table_response(c, s, st, tg, idx));
      @(posedge clock);
   endtask

   task automatic send_random_item();
      int unsigned roll;
      cmd_type     c;
      roll = $urandom_range(99);
      if (roll < 40)      c = CMD_INSERT;
      else if (roll < 70) c = CMD_READ;
      else if (roll < 95) c = CMD_RANK;
      else                c = CMD_NONE;
      send_item(c, pick_score(), 8'($urandom), $urandom, 4'($urandom));
   endtask

   task automatic test_empty_table();
      send_item(CMD_READ, 0, 0, 0, 4'd15);
      send_item(CMD_RANK, 32'sh8000_0000, 0, 0, 0);
      send_item(CMD_NONE, 32'sh7FFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 4'hF);
      send_item(CMD_INSERT, 32'sh7FFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 0);
      send_item(CMD_INSERT, 32'sh8000_0000, 8'h00, 32'h0000_0000, 0);
      // equal scores keep arrival order
      send_item(CMD_INSERT, 7, 8'h11, 32'hAAAA_0001, 0);
      send_item(CMD_INSERT, 7, 8'h22, 32'hAAAA_0002, 0);
      for (int i = 0; i < 4; i++) send_item(CMD_READ, 0, 0, 0, 4'(i));
      send_item(CMD_RANK, 7, 0, 0, 0);
      send_item(CMD_RANK, 32'sh8000_0000, 0, 0, 0);
      send_item(CMD_RANK, 32'sh7FFF_FFFF, 0, 0, 0);
   endtask

   task automatic test_fill_random();
      while (held < CAP) send_random_item();
   endtask

   task automatic test_full_table();
      logic signed [31:0] low;
      low = tbl_score[CAP-1];
      send_item(CMD_INSERT, low, 8'h5A, 32'h0BAD_0001, 0);      // refused
      send_item(CMD_RANK, low, 0, 0, 0);                        // does not qualify
      send_item(CMD_INSERT, low + 1, 8'hA5, 32'h600D_0001, 0);  // replaces lowest
      send_item(CMD_INSERT, low + 1, 8'hA6, 32'h600D_0002, 0);
      send_item(CMD_READ, 0, 0, 0, 4'd14);
      send_item(CMD_READ, 0, 0, 0, 4'd15);
      send_item(CMD_RANK, 32'sh7FFF_FFFF, 0, 0, 0);
   endtask

   task automatic test_random_mix(input int count);
      repeat (count) send_random_item();
   endtask

   task automatic test_no_idle(input int count);
      src_idle_on  = 1'b0;
      sink_idle_on = 1'b0;
      repeat (count) send_random_item();
      src_idle_on  = 1'b1;
      sink_idle_on = 1'b1;
   endtask

   task automatic test_backpressure();
      src_idle_on = 1'b0;
      hold_requests++;
      repeat (40) send_random_item();
      src_idle_on = 1'b1;
   endtask

   // response side: random idling plus long hold-offs on request
   always @(posedge clock) begin
      if (hold_requests != hold_served) begin
         hold_served++;
         stall_left = HOLD_LEN;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_ch.ready <= 1'b0;
      end else if (sink_idle_on) begin
         rsp_ch.ready <= ($urandom_range(99) >= 11);
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         errors++;
      end
   endtask

   // sample at the falling edge; the transaction moves at the next rising edge
   always @(negedge clock) begin
      rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_rsp.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual occupancy %0d",
                     $time, rsp_ch.occupancy);
            errors++;
         end else begin
            want = expected_rsp.pop_front();
            check_field("entry_score", want.entry.score, rsp_ch.entry_score);
            check_field("entry_stage", 32'(want.entry.stage), 32'(rsp_ch.entry_stage));
            check_field("entry_tag",   want.entry.tag,   rsp_ch.entry_tag);
            check_field("entry_valid", 32'(want.entry_valid), 32'(rsp_ch.entry_valid));
            check_field("rank",        32'(want.rank),        32'(rsp_ch.rank));
            check_field("qualifies",   32'(want.qualifies),   32'(rsp_ch.qualifies));
            check_field("inserted",    32'(want.inserted),    32'(rsp_ch.inserted));
            check_field("occupancy",   32'(want.occupancy),   32'(rsp_ch.occupancy));
         end
      end
   end

   initial begin
      req_ch.valid   = 1'b0;
      req_ch.command = CMD_NONE;
      req_ch.score   = '0;
      req_ch.stage   = '0;
      req_ch.tag     = '0;
      req_ch.index   = '0;
      rsp_ch.ready   = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_empty_table();
      test_fill_random();
      test_full_table();
      test_random_mix(1000);
      test_no_idle(200);
      test_backpressure();
      test_random_mix(450);

      req_ch.valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (errors == 0)
         $display("top_k_score_table_tb: PASS");
      else
         $display("top_k_score_table_tb: FAIL");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("top_k_score_table_tb: FAIL");
      $finish;
   end

endmodule

FILE: top_k_score_table.f
hw/rtl/tks_pkg.sv
hw/rtl/tks_if.sv
hw/rtl/tks_cell.sv
hw/rtl/top_k_score_table.sv
hw/rtl/tks_checker.sv
tb/top_k_score_table_tb.sv
